// ===== src/nvme_queue_pair_tracker_assert.svh =====
// assertion macros for the nvme queue pair tracker
// expects a clock named i_clk and an active-low reset named i_rst_n in the including module
`ifndef NVME_QUEUE_PAIR_TRACKER_ASSERT_SVH
`define NVME_QUEUE_PAIR_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define NQPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NQPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NQPT_ASSERT_NOW(lbl, ante, cons, msg)
`define NQPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/nqpt_pkg.sv =====
// shared constants and types for the nvme queue pair tracker
// no dependencies
package nqpt_pkg;

    localparam int MAX_ENTRIES   = 65536;
    localparam int ENTRY_W       = 17;
    localparam int PTR_W         = 16;
    localparam int LIMIT_W       = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;

    localparam logic [ENTRY_W-1:0] ENTRIES_MIN   = ENTRY_W'(2);
    localparam logic [ENTRY_W-1:0] ENTRIES_MAX   = ENTRY_W'(MAX_ENTRIES);
    localparam logic [ENTRY_W-1:0] ENTRIES_RESET = ENTRY_W'(64);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(1000000);

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENTRIES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT    = CFG_IDX_W'(1);

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    typedef struct packed {
        logic             take;
        logic [PTR_W-1:0] cmd_id;
        logic [PTR_W-1:0] slot;
        logic [PTR_W-1:0] doorbell;
    } t_sq_res;

    typedef struct packed {
        logic             consume;
        logic [PTR_W-1:0] slot;
        logic [PTR_W-1:0] doorbell;
        logic [PTR_W-1:0] sq_head;
        logic             timed_out;
    } t_cq_res;

endpackage

// ===== src/nqpt_sq.sv =====
// submission side: tail pointer and command id counter
// depends on nqpt_pkg
module nqpt_sq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic                        i_allow,
    input  logic [nqpt_pkg::ENTRY_W-1:0] i_entries,
    output nqpt_pkg::t_sq_res           o_res
);
    import nqpt_pkg::*;

    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [PTR_W-1:0]   r_id, n_id;
    logic [PTR_W-1:0]   tail_sel;
    logic [ENTRY_W-1:0] tail_inc;

    always_comb begin
        // a tail left beyond a shrunk queue restarts at slot zero
        tail_sel = ({1'b0, r_tail} < i_entries) ? r_tail : '0;
        tail_inc = {1'b0, tail_sel} + ENTRY_W'(1);
        n_tail   = r_tail;
        n_id     = r_id;
        o_res    = '0;
        if (i_go && i_allow) begin
            n_tail         = (tail_inc >= i_entries) ? '0 : tail_inc[PTR_W-1:0];
            n_id           = r_id + PTR_W'(1);
            o_res.take     = 1'b1;
            o_res.cmd_id   = r_id;
            o_res.slot     = tail_sel;
            o_res.doorbell = n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= '0;
            r_id   <= '0;
        end else begin
            r_tail <= n_tail;
            r_id   <= n_id;
        end
    end

endmodule

// ===== src/nqpt_cq.sv =====
// completion side: head pointer, expected phase, wait counter, device head
// depends on nqpt_pkg
module nqpt_cq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic                        i_phase,
    input  logic [nqpt_pkg::PTR_W-1:0]   i_sq_head,
    input  logic [nqpt_pkg::ENTRY_W-1:0] i_entries,
    input  logic [nqpt_pkg::LIMIT_W-1:0] i_limit,
    output nqpt_pkg::t_cq_res           o_res
);
    import nqpt_pkg::*;

    logic [PTR_W-1:0]   r_head, n_head;
    logic               r_exp_phase, n_exp_phase;
    logic [LIMIT_W-1:0] r_wait, n_wait;
    logic [PTR_W-1:0]   r_dev_head, n_dev_head;
    logic [PTR_W-1:0]   head_sel;
    logic [ENTRY_W-1:0] head_inc;
    logic [LIMIT_W-1:0] limit_eff;
    logic [LIMIT_W-1:0] wait_inc;

    always_comb begin
        head_sel    = ({1'b0, r_head} < i_entries) ? r_head : '0;
        head_inc    = {1'b0, head_sel} + ENTRY_W'(1);
        limit_eff   = (i_limit == '0) ? LIMIT_W'(1) : i_limit;
        wait_inc    = r_wait + LIMIT_W'(1);
        n_head      = r_head;
        n_exp_phase = r_exp_phase;
        n_wait      = r_wait;
        n_dev_head  = r_dev_head;
        o_res       = '0;
        if (i_go) begin
            if (i_phase == r_exp_phase) begin
                n_dev_head = i_sq_head;
                n_wait     = '0;
                if (head_inc >= i_entries) begin
                    n_head      = '0;
                    n_exp_phase = ~r_exp_phase;
                end else begin
                    n_head = head_inc[PTR_W-1:0];
                end
                o_res.consume  = 1'b1;
                o_res.slot     = head_sel;
                o_res.doorbell = n_head;
            end else if (wait_inc >= limit_eff) begin
                n_wait          = '0;
                o_res.timed_out = 1'b1;
            end else begin
                n_wait = wait_inc;
            end
        end
        o_res.sq_head = n_dev_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_exp_phase <= 1'b1;
            r_wait      <= '0;
            r_dev_head  <= '0;
        end else begin
            r_head      <= n_head;
            r_exp_phase <= n_exp_phase;
            r_wait      <= n_wait;
            r_dev_head  <= n_dev_head;
        end
    end

endmodule

// ===== src/nvme_queue_pair_tracker.sv =====
// nvme queue pair tracker top: input register, queue logic, result register.
// the result strobe is registered: a taken transaction passes the input register, then the result register.
// throughput: one transaction per cycle; busy stays low, set by the single
// state update per cycle in the submission and completion logic.
// reset (synchronous, active low) restores pointers, counters, configuration and valid flags.
// results cannot be held off by the receiver.
`include "nvme_queue_pair_tracker_assert.svh"
module nvme_queue_pair_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cmd,
    input  logic                           i_cqe_phase,
    input  logic [15:0]                    i_cqe_sq_head,
    input  logic                           i_cfg_we,
    input  logic [nqpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nqpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic                           o_accepted,
    output logic [15:0]                    o_cmd_id,
    output logic [15:0]                    o_sq_slot,
    output logic [15:0]                    o_sq_doorbell,
    output logic [15:0]                    o_cq_slot,
    output logic [15:0]                    o_cq_doorbell,
    output logic [15:0]                    o_sq_head_seen,
    output logic [15:0]                    o_free_slots,
    output logic                           o_timed_out
);
    import nqpt_pkg::*;

    logic [ENTRY_W-1:0] r_entries;
    logic [LIMIT_W-1:0] r_limit;

    logic               r_vld;
    logic               r_cmd;
    logic               r_phase;
    logic [PTR_W-1:0]   r_sqh;

    logic [PTR_W-1:0]   r_outst, n_outst;

    logic               r_out_vld;
    logic               r_out_acc;
    logic [PTR_W-1:0]   r_out_cmd_id;
    logic [PTR_W-1:0]   r_out_sq_slot;
    logic [PTR_W-1:0]   r_out_sq_db;
    logic [PTR_W-1:0]   r_out_cq_slot;
    logic [PTR_W-1:0]   r_out_cq_db;
    logic [PTR_W-1:0]   r_out_sqh;
    logic [PTR_W-1:0]   r_out_free;
    logic               r_out_tmo;

    logic [ENTRY_W-1:0] entries_eff;
    logic [PTR_W-1:0]   cap;
    logic               allow;
    logic [PTR_W-1:0]   free_cnt;
    t_sq_res            sq_res;
    t_cq_res            cq_res;

    // the tracker takes a transaction in every cycle
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
            r_limit   <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUEUE_ENTRIES: r_entries <= i_cfg_data[ENTRY_W-1:0];
                CFG_POLL_LIMIT:    r_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
        r_cmd   <= i_cmd;
        r_phase <= i_cqe_phase;
        r_sqh   <= i_cqe_sq_head;
    end

    always_comb begin
        if (r_entries < ENTRIES_MIN) begin
            entries_eff = ENTRIES_MIN;
        end else if (r_entries > ENTRIES_MAX) begin
            entries_eff = ENTRIES_MAX;
        end else begin
            entries_eff = r_entries;
        end
        cap   = PTR_W'(entries_eff - ENTRY_W'(1));
        allow = r_outst < cap;
    end

    nqpt_sq u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_vld && (r_cmd == CMD_SUBMIT)),
        .i_allow   (allow),
        .i_entries (entries_eff),
        .o_res     (sq_res)
    );

    nqpt_cq u_cq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_vld && (r_cmd == CMD_POLL)),
        .i_phase   (r_phase),
        .i_sq_head (r_sqh),
        .i_entries (entries_eff),
        .i_limit   (r_limit),
        .o_res     (cq_res)
    );

    always_comb begin
        n_outst = r_outst;
        if (sq_res.take) begin
            n_outst = r_outst + PTR_W'(1);
        end else if (cq_res.consume && (r_outst != '0)) begin
            n_outst = r_outst - PTR_W'(1);
        end
        free_cnt = (n_outst >= cap) ? '0 : cap - n_outst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_outst   <= n_outst;
            r_out_vld <= r_vld;
        end
        r_out_acc     <= sq_res.take | cq_res.consume;
        r_out_cmd_id  <= sq_res.cmd_id;
        r_out_sq_slot <= sq_res.slot;
        r_out_sq_db   <= sq_res.doorbell;
        r_out_cq_slot <= cq_res.slot;
        r_out_cq_db   <= cq_res.doorbell;
        r_out_sqh     <= cq_res.sq_head;
        r_out_free    <= free_cnt;
        r_out_tmo     <= cq_res.timed_out;
    end

    assign o_valid        = r_out_vld;
    assign o_accepted     = r_out_acc;
    assign o_cmd_id       = r_out_cmd_id;
    assign o_sq_slot      = r_out_sq_slot;
    assign o_sq_doorbell  = r_out_sq_db;
    assign o_cq_slot      = r_out_cq_slot;
    assign o_cq_doorbell  = r_out_cq_db;
    assign o_sq_head_seen = r_out_sqh;
    assign o_free_slots   = r_out_free;
    assign o_timed_out    = r_out_tmo;

    `NQPT_ASSERT_NOW(a_tmo_not_acc, o_valid && o_timed_out, !o_accepted, "timeout on a consumed entry")
    `NQPT_ASSERT_NEXT(a_poll_no_sq, r_vld && (r_cmd == CMD_POLL), (o_cmd_id == '0) && (o_sq_slot == '0) && (o_sq_doorbell == '0), "poll drove submission fields")
    `NQPT_ASSERT_NOW(a_strobe_src, o_valid, $past(r_vld), "result strobe without a transaction")
    `NQPT_ASSERT_NEXT(a_submit_no_tmo, r_vld && (r_cmd == CMD_SUBMIT), !o_timed_out && (o_cq_slot == '0), "submit drove completion fields")

endmodule

// ===== test/nvme_queue_pair_tracker_tb.sv =====
// testbench for nvme_queue_pair_tracker: directed table then bursty random queue traffic,
// every result checked against a local queue pair model or a directed expected value; depends on nqpt_pkg
module nvme_queue_pair_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nqpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 8;

    typedef struct packed {
        logic        accepted;
        logic [15:0] cmd_id;
        logic [15:0] sq_slot;
        logic [15:0] sq_doorbell;
        logic [15:0] cq_slot;
        logic [15:0] cq_doorbell;
        logic [15:0] sq_head_seen;
        logic [15:0] free_slots;
        logic        timed_out;
    } t_qp_result;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  cmd;
        logic                  ph;
        logic [15:0]           sqh;
        bit                    has_gold;
        t_qp_result            gold;
    } t_dir_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic                  i_cmd         = CMD_SUBMIT;
    logic                  i_cqe_phase   = 1'b0;
    logic [15:0]           i_cqe_sq_head = '0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = CFG_QUEUE_ENTRIES;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_valid;
    logic                  o_accepted;
    logic [15:0]           o_cmd_id;
    logic [15:0]           o_sq_slot;
    logic [15:0]           o_sq_doorbell;
    logic [15:0]           o_cq_slot;
    logic [15:0]           o_cq_doorbell;
    logic [15:0]           o_sq_head_seen;
    logic [15:0]           o_free_slots;
    logic                  o_timed_out;

    nvme_queue_pair_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_cqe_phase    (i_cqe_phase),
        .i_cqe_sq_head  (i_cqe_sq_head),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_accepted     (o_accepted),
        .o_cmd_id       (o_cmd_id),
        .o_sq_slot      (o_sq_slot),
        .o_sq_doorbell  (o_sq_doorbell),
        .o_cq_slot      (o_cq_slot),
        .o_cq_doorbell  (o_cq_doorbell),
        .o_sq_head_seen (o_sq_head_seen),
        .o_free_slots   (o_free_slots),
        .o_timed_out    (o_timed_out)
    );

    always #5 i_clk = ~i_clk;

    // model of the queue pair: configuration and bookkeeping state
    logic [ENTRY_W-1:0] qp_entries_reg;
    logic [LIMIT_W-1:0] qp_limit_reg;
    logic [15:0]        qp_tail;
    logic [15:0]        qp_head;
    logic               qp_phase;
    logic [15:0]        qp_next_id;
    logic [15:0]        qp_outstanding;
    logic [15:0]        qp_head_seen;
    logic [23:0]        qp_wait_cnt;

    t_qp_result pending_results[$];
    t_dir_row   dir_rows[$];

    int n_items;
    int n_checked;
    int n_err;
    int n_tmo;
    int n_cfg;
    int idle_cycles;
    int burst_left;
    bit no_idle;

    t_qp_result mon_act;
    t_qp_result mon_exp;

    function automatic t_qp_result mk_res(logic acc, logic [15:0] cid, logic [15:0] sslot,
                                          logic [15:0] sdb, logic [15:0] cslot,
                                          logic [15:0] cdb, logic [15:0] seen,
                                          logic [15:0] free, logic tmo);
        return {acc, cid, sslot, sdb, cslot, cdb, seen, free, tmo};
    endfunction

    function automatic string fmt_res(t_qp_result r);
        return $sformatf("acc=%0b id=%h sq_slot=%h sq_db=%h cq_slot=%h cq_db=%h seen=%h free=%0d tmo=%0b",
                         r.accepted, r.cmd_id, r.sq_slot, r.sq_doorbell, r.cq_slot,
                         r.cq_doorbell, r.sq_head_seen, r.free_slots, r.timed_out);
    endfunction

    // advances the queue pair model by one transaction
    function automatic t_qp_result track_queue_pair(logic cmd, logic ph, logic [15:0] sqh);
        logic [ENTRY_W-1:0] e;
        logic [ENTRY_W-1:0] ptr;
        logic [LIMIT_W-1:0] lim;
        t_qp_result         r;
        e = (qp_entries_reg < ENTRIES_MIN) ? ENTRIES_MIN :
            (qp_entries_reg > ENTRIES_MAX) ? ENTRIES_MAX : qp_entries_reg;
        r = '0;
        if (cmd == CMD_SUBMIT) begin
            if ({1'b0, qp_outstanding} < e - 1) begin
                // a tail left beyond a shrunken queue restarts at slot 0
                ptr = ({1'b0, qp_tail} < e) ? {1'b0, qp_tail} : '0;
                r.accepted = 1'b1;
                r.cmd_id = qp_next_id;
                qp_next_id = qp_next_id + 16'd1;
                r.sq_slot = ptr[15:0];
                ptr = ptr + 1'b1;
                if (ptr >= e) ptr = '0;
                qp_tail = ptr[15:0];
                r.sq_doorbell = ptr[15:0];
                qp_outstanding = qp_outstanding + 16'd1;
            end
        end else if (ph == qp_phase) begin
            ptr = ({1'b0, qp_head} < e) ? {1'b0, qp_head} : '0;
            r.accepted = 1'b1;
            r.cq_slot = ptr[15:0];
            qp_head_seen = sqh;
            ptr = ptr + 1'b1;
            if (ptr >= e) begin
                ptr = '0;
                qp_phase = ~qp_phase;
            end
            qp_head = ptr[15:0];
            r.cq_doorbell = ptr[15:0];
            if (qp_outstanding != 16'd0) qp_outstanding = qp_outstanding - 16'd1;
            qp_wait_cnt = '0;
        end else begin
            lim = (qp_limit_reg == '0) ? LIMIT_W'(1) : qp_limit_reg;
            qp_wait_cnt = qp_wait_cnt + 24'd1;
            if (qp_wait_cnt >= lim) begin
                r.timed_out = 1'b1;
                qp_wait_cnt = '0;
            end
        end
        r.sq_head_seen = qp_head_seen;
        r.free_slots = ({1'b0, qp_outstanding} >= e - 1) ? 16'd0 :
                       16'(e - 1 - {1'b0, qp_outstanding});
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_dir_row op_row(logic cmd, logic ph, logic [15:0] sqh);
        t_dir_row row;
        row = '{default: '0};
        row.cmd = cmd;
        row.ph = ph;
        row.sqh = sqh;
        return row;
    endfunction

    function automatic t_dir_row chk_row(logic cmd, logic ph, logic [15:0] sqh, t_qp_result gold);
        t_dir_row row;
        row = op_row(cmd, ph, sqh);
        row.has_gold = 1'b1;
        row.gold = gold;
        return row;
    endfunction

    // appends one row to the directed table
    function automatic void add_row(t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // holds start until the transaction is taken, then records what should come back
    task automatic drive_item(logic cmd, logic ph, logic [15:0] sqh, bit has_gold,
                              t_qp_result gold);
        t_qp_result r;
        start <= 1'b1;
        i_cmd <= cmd;
        i_cqe_phase <= ph;
        i_cqe_sq_head <= sqh;
        do @(posedge i_clk); while (busy);
        r = track_queue_pair(cmd, ph, sqh);
        pending_results.insert(pending_results.size(), has_gold ? gold : r);
        n_items++;
        if (r.timed_out) n_tmo++;
    endtask

    task automatic pace();
        int gap;
        if (!no_idle) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_QUEUE_ENTRIES) qp_entries_reg = data[ENTRY_W-1:0];
        else if (idx == CFG_POLL_LIMIT) qp_limit_reg = data[LIMIT_W-1:0];
        n_cfg++;
    endtask

    // mostly host-like traffic: submits and polls with the right phase, plus wrong-phase streaks
    task automatic run_phase(logic [CFG_DATA_W-1:0] entries, logic [CFG_DATA_W-1:0] limit,
                             int n);
        int          k;
        int          r;
        int          sub_pct;
        int          streak_left;
        logic [15:0] sqh;
        write_reg(CFG_QUEUE_ENTRIES, entries);
        write_reg(CFG_POLL_LIMIT, limit);
        no_idle = ($urandom_range(0, 3) == 0);
        sub_pct = $urandom_range(30, 60);
        streak_left = 0;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0) sqh = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else sqh = 16'($urandom());
            if (streak_left > 0) begin
                streak_left--;
                drive_item(CMD_POLL, ~qp_phase, sqh, 1'b0, '0);
            end else if (r < sub_pct || (r < 85 && qp_outstanding == 16'd0 &&
                                         $urandom_range(0, 1) == 1)) begin
                drive_item(CMD_SUBMIT, 1'($urandom()), sqh, 1'b0, '0);
            end else if (r < 85) begin
                drive_item(CMD_POLL, qp_phase, sqh, 1'b0, '0);
            end else begin
                streak_left = $urandom_range(0, 5);
                drive_item(CMD_POLL, ~qp_phase, sqh, 1'b0, '0);
            end
            pace();
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            mon_act = {o_accepted, o_cmd_id, o_sq_slot, o_sq_doorbell, o_cq_slot,
                       o_cq_doorbell, o_sq_head_seen, o_free_slots, o_timed_out};
            if (pending_results.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("tb: unexpected result %s", fmt_res(mon_act));
            end else begin
                mon_exp = pending_results.pop_front();
                n_checked++;
                if (mon_act !== mon_exp) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("tb: mismatch on result %0d", n_checked);
                        $display("    expected %s", fmt_res(mon_exp));
                        $display("    actual   %s", fmt_res(mon_act));
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: timeout after %0d idle cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        n_items = 0;
        n_checked = 0;
        n_err = 0;
        n_tmo = 0;
        n_cfg = 0;
        idle_cycles = 0;
        burst_left = 0;
        no_idle = 1'b0;
        qp_entries_reg = ENTRIES_RESET;
        qp_limit_reg = LIMIT_RESET;
        qp_tail = '0;
        qp_head = '0;
        qp_phase = 1'b1;
        qp_next_id = '0;
        qp_outstanding = '0;
        qp_head_seen = '0;
        qp_wait_cnt = '0;

        // reset defaults, minimum queue and zero limit, maximum sizes, entries 1 with limit 3
        add_row(chk_row(CMD_SUBMIT, 1'b1, 16'h0000,
                        mk_res(1'b1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0,
                               16'd62, 1'b0)));
        add_row(chk_row(CMD_POLL, 1'b0, 16'h5555,
                        mk_res(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                               16'd62, 1'b0)));
        add_row(chk_row(CMD_POLL, 1'b1, 16'hFFFF,
                        mk_res(1'b0 | 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1,
                               16'hFFFF, 16'd63, 1'b0)));
        // nothing outstanding: still consumed
        add_row(op_row(CMD_POLL, 1'b1, 16'h0000));
        add_row(cfg_row(CFG_QUEUE_ENTRIES, 24'd0));
        add_row(cfg_row(CFG_POLL_LIMIT, 24'd0));
        add_row(op_row(CMD_SUBMIT, 1'b0, 16'hAAAA));
        // queue of two holds one command, so this one is refused
        add_row(chk_row(CMD_SUBMIT, 1'b1, 16'h0000,
                        mk_res(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                               16'd0, 1'b0)));
        add_row(chk_row(CMD_POLL, 1'b0, 16'hFFFF,
                        mk_res(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                               16'd0, 1'b1)));
        // head left beyond the shrunken queue
        add_row(op_row(CMD_POLL, 1'b1, 16'h1234));
        add_row(op_row(CMD_POLL, 1'b1, 16'hFFFF));
        add_row(op_row(CMD_POLL, 1'b1, 16'h0001));
        add_row(op_row(CMD_POLL, 1'b0, 16'h8000));
        add_row(cfg_row(CFG_QUEUE_ENTRIES, 24'h01FFFF));
        add_row(cfg_row(CFG_POLL_LIMIT, 24'hFFFFFF));
        add_row(op_row(CMD_SUBMIT, 1'b0, 16'h0000));
        add_row(op_row(CMD_SUBMIT, 1'b1, 16'hFFFF));
        add_row(op_row(CMD_POLL, 1'b1, 16'h7FFF));
        add_row(op_row(CMD_POLL, 1'b0, 16'h00FF));
        add_row(cfg_row(CFG_QUEUE_ENTRIES, 24'd1));
        add_row(cfg_row(CFG_POLL_LIMIT, 24'd3));
        add_row(op_row(CMD_POLL, 1'b1, 16'hFF00));
        add_row(op_row(CMD_POLL, 1'b1, 16'h0F0F));
        add_row(op_row(CMD_POLL, 1'b1, 16'hF0F0));
        add_row(op_row(CMD_POLL, 1'b0, 16'h3C3C));
        add_row(op_row(CMD_SUBMIT, 1'b0, 16'hC3C3));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                drive_item(dir_rows[i].cmd, dir_rows[i].ph, dir_rows[i].sqh,
                           dir_rows[i].has_gold, dir_rows[i].gold);
                pace();
            end
        end

        run_phase(24'd2, 24'd1, 85);
        run_phase(24'd4, 24'd2, 85);
        run_phase(24'd0, 24'd0, 85);
        run_phase(24'd8, 24'd5, 85);
        // upper data bits beyond the entries register are dropped
        run_phase(24'hFE0010, 24'd3, 85);
        run_phase(24'd1, 24'hFFFFFF, 85);
        run_phase(24'h01FFFF, 24'd4, 25);
        run_phase(24'd65536, 24'd1, 25);
        run_phase(24'd3, 24'd7, 85);
        run_phase(24'($urandom_range(2, 40)), 24'($urandom_range(1, 9)), 85);
        run_phase(24'd64, 24'd1000000, 85);

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_err += pending_results.size();
            $display("tb: %0d expected results never arrived", pending_results.size());
        end

        $display("tb: %0d transactions sent, %0d results checked, %0d mismatches",
                 n_items, n_checked, n_err);
        $display("tb: %0d register writes, %0d poll timeouts predicted", n_cfg, n_tmo);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/nqpt_pkg.sv
src/nqpt_sq.sv
src/nqpt_cq.sv
src/nvme_queue_pair_tracker.sv
test/nvme_queue_pair_tracker_tb.sv
